/* src/vcc_pkg.sv */
// ----------------------------------------------------------------------------
// View cone cull package
// Shared constants, codes and state types of the view cone cull block.
// ----------------------------------------------------------------------------
package vcc_pkg;

  localparam int unsigned MONITOR_SLOTS_DEF = 16;

  localparam int unsigned CFG_IDX_W = 1;
  localparam logic [CFG_IDX_W-1:0] CFG_COS_THRESHOLD = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_HOLD_FRAMES = 1'b1;

  localparam logic signed [15:0] COS_THRESHOLD_RST = 16'sd9397;
  localparam logic [7:0] HOLD_FRAMES_RST = 8'd30;
  localparam logic signed [15:0] UNIT_ONE = 16'sd16384;

  localparam logic [1:0] KIND_LEFT = 2'd0;
  localparam logic [1:0] KIND_RIGHT = 2'd1;
  localparam logic [1:0] KIND_TEST = 2'd2;

  localparam logic [1:0] ACT_NONE = 2'd0;
  localparam logic [1:0] ACT_RESUME = 2'd1;
  localparam logic [1:0] ACT_PAUSE = 2'd2;

  localparam int unsigned QUOT_W = 25;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_NORM,
    ST_MUL,
    ST_ROOT,
    ST_DONE
  } vcc_state_e;

  typedef enum logic [1:0] {
    SD_IDLE,
    SD_ROOT,
    SD_PREP,
    SD_DIV
  } sd_state_e;

endpackage

/* src/vcc_sqdiv.sv */
// ----------------------------------------------------------------------------
// Root and divide unit
// Bit-serial integer square root of the squared length, followed by a
// restoring division of the rounded dot product magnitude by that length.
// ----------------------------------------------------------------------------
module vcc_sqdiv (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       start_i,
  input  logic [63:0]                sumsq_i,
  input  logic [63:0]                dot_mag_i,
  output logic                       done_o,
  output logic [vcc_pkg::QUOT_W-1:0] quot_o
);
  import vcc_pkg::*;

  sd_state_e state_q, state_d;
  logic [63:0] n_q, r_q, bit_q;
  logic [31:0] len_q, rem_q;
  logic [QUOT_W-1:0] num_q, quot_q;
  logic [4:0] cnt_q;
  logic done_q;

  logic [63:0] trial;
  logic [31:0] len_c;
  logic [63:0] num_c;
  logic [32:0] rem2;
  logic fits;

  assign trial = r_q + bit_q;
  assign len_c = (r_q == 64'd0) ? 32'd1 : r_q[31:0];
  assign num_c = dot_mag_i + {33'd0, len_c[31:1]};
  assign rem2 = {rem_q, num_q[QUOT_W-1]};
  assign fits = rem2 >= {1'b0, len_q};

  always_comb begin
    state_d = state_q;
    case (state_q)
      SD_IDLE: if (start_i) state_d = SD_ROOT;
      SD_ROOT: if (bit_q == 64'd1) state_d = SD_PREP;
      SD_PREP: state_d = SD_DIV;
      SD_DIV:  if (cnt_q == 5'd0) state_d = SD_IDLE;
      default: state_d = SD_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= SD_IDLE;
      done_q <= 1'b0;
    end else begin
      state_q <= state_d;
      done_q <= (state_q == SD_DIV) && (cnt_q == 5'd0);
    end
  end

  always_ff @(posedge clk_i) begin
    case (state_q)
      SD_IDLE: begin
        n_q <= sumsq_i;
        r_q <= 64'd0;
        bit_q <= 64'd1 << 62;
      end
      SD_ROOT: begin
        if (n_q >= trial) begin
          n_q <= n_q - trial;
          r_q <= (r_q >> 1) + bit_q;
        end else begin
          r_q <= r_q >> 1;
        end
        bit_q <= bit_q >> 2;
      end
      SD_PREP: begin
        len_q <= len_c;
        rem_q <= num_c[QUOT_W+31:QUOT_W];
        num_q <= num_c[QUOT_W-1:0];
        quot_q <= '0;
        cnt_q <= 5'(QUOT_W - 1);
      end
      SD_DIV: begin
        rem_q <= fits ? 32'(rem2 - {1'b0, len_q}) : rem2[31:0];
        num_q <= num_q << 1;
        quot_q <= {quot_q[QUOT_W-2:0], fits};
        cnt_q <= cnt_q - 5'd1;
      end
      default: ;
    endcase
  end

  assign done_o = done_q;
  assign quot_o = quot_q;

endmodule

/* src/view_cone_cull_with_hysteresis.sv */
// ----------------------------------------------------------------------------
// View cone cull with hysteresis
// Tests monitor positions against the head view cone and keeps a hold
// countdown per monitor to resume or pause its decoder.
// ----------------------------------------------------------------------------
// A monitor test runs bit by bit range normalization of the direction, the
// single shared 32 by 32 multiplier for the forward vector, the squared length
// and the dot product, then a bit-serial square root and a restoring division
// in the root and divide unit. A monitor that sits exactly at the eye point
// skips the root and division. The input is not ready while a test runs; a
// finished result waits in the output register while the next transaction is
// taken.
module view_cone_cull_with_hysteresis #(
  parameter int unsigned MONITOR_SLOTS = vcc_pkg::MONITOR_SLOTS_DEF
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_valid_i,
  output logic                           cfg_ready_o,
  input  logic [vcc_pkg::CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [15:0]                    cfg_data_i,
  input  logic                           in_valid_i,
  output logic                           in_ready_o,
  input  logic [1:0]                     kind_i,
  input  logic [3:0]                     monitor_index_i,
  input  logic signed [31:0]             pos_x_i,
  input  logic signed [31:0]             pos_y_i,
  input  logic signed [31:0]             pos_z_i,
  input  logic signed [15:0]             rot_x_i,
  input  logic signed [15:0]             rot_y_i,
  input  logic signed [15:0]             rot_z_i,
  input  logic signed [15:0]             rot_w_i,
  input  logic                           decoder_present_i,
  input  logic                           decoder_running_i,
  output logic                           out_valid_o,
  input  logic                           out_ready_i,
  output logic [3:0]                     result_monitor_o,
  output logic                           in_view_o,
  output logic signed [15:0]             alignment_o,
  output logic [1:0]                     action_o,
  output logic [7:0]                     hold_left_o
);
  import vcc_pkg::*;

  localparam int unsigned IDX_W = (MONITOR_SLOTS > 1) ? $clog2(MONITOR_SLOTS) : 1;

  vcc_state_e state_q, state_d;

  logic signed [15:0] thr_q;
  logic [7:0] hold_q;
  logic signed [31:0] left_q [3];
  logic signed [31:0] right_q [3];
  logic signed [15:0] rot_q [4];
  logic [7:0] cnt_q [MONITOR_SLOTS];

  logic signed [33:0] e_q [3];
  logic zero_q, run_q;
  logic [3:0] slot_q;
  logic [3:0] step_q;
  logic signed [63:0] prod_q, acc_a_q, acc_b_q, acc_c_q, ss_q, dot_q;
  logic signed [16:0] align_q;

  logic out_valid_q, in_view_q;
  logic [3:0] res_mon_q;
  logic signed [15:0] res_align_q;
  logic [1:0] act_q;
  logic [7:0] left_cnt_q;

  logic in_acc, test_go, start_sd, sd_done, load_out;
  logic [QUOT_W-1:0] quot;
  logic signed [31:0] pos_in [3];
  logic signed [33:0] d_in [3];
  logic [33:0] mag [3];
  logic [33:0] m_max;
  logic signed [31:0] op_a, op_b;
  logic signed [63:0] prod_d;
  logic signed [63:0] fx_w, fy_w, fz_w;
  logic signed [19:0] f [3];
  logic signed [20:0] neg_fz;
  logic [QUOT_W-1:0] q_sat;
  logic signed [16:0] align_div, align_zero;
  logic [IDX_W-1:0] idx;
  logic [7:0] cur_cnt, new_cnt;
  logic visible;
  logic [1:0] act_d;

  assign cfg_ready_o = 1'b1;
  assign in_acc = in_valid_i && in_ready_o;
  assign test_go = in_acc && (kind_i == KIND_TEST) && decoder_present_i &&
                   (32'(monitor_index_i) < MONITOR_SLOTS);

  assign pos_in[0] = pos_x_i;
  assign pos_in[1] = pos_y_i;
  assign pos_in[2] = pos_z_i;

  always_comb begin
    m_max = '0;
    for (int i = 0; i < 3; i++) begin
      d_in[i] = 34'(pos_in[i]) * 34'sd2 - 34'(left_q[i]) - 34'(right_q[i]);
      mag[i] = e_q[i][33] ? 34'(-e_q[i]) : 34'(e_q[i]);
      if (mag[i] > m_max) m_max = mag[i];
    end
  end

  assign fx_w = (-(acc_a_q * 64'sd2) + 64'sd8192) >>> 14;
  assign fy_w = ((acc_b_q * 64'sd2) + 64'sd8192) >>> 14;
  assign fz_w = ((acc_c_q * 64'sd2) - (64'sd1 <<< 28) + 64'sd8192) >>> 14;
  assign f[0] = fx_w[19:0];
  assign f[1] = fy_w[19:0];
  assign f[2] = fz_w[19:0];

  always_comb begin
    op_a = '0;
    op_b = '0;
    case (step_q)
      4'd0: begin op_a = 32'(rot_q[0]); op_b = 32'(rot_q[2]); end
      4'd1: begin op_a = 32'(rot_q[3]); op_b = 32'(rot_q[1]); end
      4'd2: begin op_a = 32'(rot_q[3]); op_b = 32'(rot_q[0]); end
      4'd3: begin op_a = 32'(rot_q[1]); op_b = 32'(rot_q[2]); end
      4'd4: begin op_a = 32'(rot_q[0]); op_b = 32'(rot_q[0]); end
      4'd5: begin op_a = 32'(rot_q[1]); op_b = 32'(rot_q[1]); end
      4'd6: begin op_a = e_q[0][31:0]; op_b = e_q[0][31:0]; end
      4'd7: begin op_a = e_q[1][31:0]; op_b = e_q[1][31:0]; end
      4'd8: begin op_a = e_q[2][31:0]; op_b = e_q[2][31:0]; end
      4'd9: begin op_a = 32'(f[0]); op_b = e_q[0][31:0]; end
      4'd10: begin op_a = 32'(f[1]); op_b = e_q[1][31:0]; end
      4'd11: begin op_a = 32'(f[2]); op_b = e_q[2][31:0]; end
      default: ;
    endcase
  end

  assign prod_d = op_a * op_b;

  vcc_sqdiv u_sqdiv (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .start_i   (start_sd),
    .sumsq_i   (ss_q),
    .dot_mag_i (dot_q[63] ? 64'(-dot_q) : 64'(dot_q)),
    .done_o    (sd_done),
    .quot_o    (quot)
  );

  assign q_sat = (quot > QUOT_W'(UNIT_ONE)) ? QUOT_W'(UNIT_ONE) : quot;
  assign align_div = dot_q[63] ? -17'(q_sat) : 17'(q_sat);
  assign neg_fz = -21'(f[2]);
  assign align_zero = (neg_fz > 21'(UNIT_ONE)) ? 17'(UNIT_ONE) :
                      (neg_fz < -21'(UNIT_ONE)) ? -17'(UNIT_ONE) : neg_fz[16:0];

  assign idx = IDX_W'(slot_q);
  assign cur_cnt = cnt_q[idx];
  assign visible = align_q >= thr_q;

  always_comb begin
    new_cnt = cur_cnt;
    act_d = ACT_NONE;
    if (visible) begin
      new_cnt = hold_q;
      if (!run_q) act_d = ACT_RESUME;
    end else if (cur_cnt != 8'd0) begin
      new_cnt = cur_cnt - 8'd1;
    end else if (run_q) begin
      act_d = ACT_PAUSE;
    end
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: if (test_go) state_d = ST_NORM;
      ST_NORM: begin
        if (m_max == 34'd0 ||
            (m_max < (34'd1 << 30) && m_max >= (34'd1 << 29))) begin
          state_d = ST_MUL;
        end
      end
      ST_MUL: if (step_q == 4'd12) state_d = zero_q ? ST_DONE : ST_ROOT;
      ST_ROOT: if (sd_done) state_d = ST_DONE;
      ST_DONE: if (!out_valid_q || out_ready_i) state_d = ST_IDLE;
      default: state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    in_ready_o = (state_q == ST_IDLE);
    start_sd = (state_q == ST_MUL) && (step_q == 4'd12) && !zero_q;
    load_out = (state_q == ST_DONE) && (!out_valid_q || out_ready_i);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      thr_q <= COS_THRESHOLD_RST;
      hold_q <= HOLD_FRAMES_RST;
      out_valid_q <= 1'b0;
      for (int i = 0; i < 3; i++) begin
        left_q[i] <= '0;
        right_q[i] <= '0;
      end
      rot_q[0] <= '0;
      rot_q[1] <= '0;
      rot_q[2] <= '0;
      rot_q[3] <= UNIT_ONE;
      for (int i = 0; i < MONITOR_SLOTS; i++) begin
        cnt_q[i] <= HOLD_FRAMES_RST;
      end
    end else begin
      state_q <= state_d;
      if (cfg_valid_i) begin
        case (cfg_index_i)
          CFG_COS_THRESHOLD: thr_q <= cfg_data_i;
          CFG_HOLD_FRAMES: hold_q <= cfg_data_i[7:0];
          default: ;
        endcase
      end
      if (in_acc && kind_i == KIND_LEFT) begin
        for (int i = 0; i < 3; i++) left_q[i] <= pos_in[i];
        rot_q[0] <= rot_x_i;
        rot_q[1] <= rot_y_i;
        rot_q[2] <= rot_z_i;
        rot_q[3] <= rot_w_i;
      end
      if (in_acc && kind_i == KIND_RIGHT) begin
        for (int i = 0; i < 3; i++) right_q[i] <= pos_in[i];
      end
      if (load_out) begin
        out_valid_q <= 1'b1;
        cnt_q[idx] <= new_cnt;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (test_go) begin
      for (int i = 0; i < 3; i++) e_q[i] <= d_in[i];
      slot_q <= monitor_index_i;
      run_q <= decoder_running_i;
      zero_q <= 1'b0;
      step_q <= '0;
      acc_a_q <= '0;
      acc_b_q <= '0;
      acc_c_q <= '0;
      ss_q <= '0;
      dot_q <= '0;
    end
    if (state_q == ST_NORM) begin
      if (m_max == 34'd0) begin
        zero_q <= 1'b1;
      end else if (m_max >= (34'd1 << 30)) begin
        for (int i = 0; i < 3; i++) e_q[i] <= e_q[i] >>> 1;
      end else if (m_max < (34'd1 << 29)) begin
        for (int i = 0; i < 3; i++) e_q[i] <= e_q[i] <<< 1;
      end
    end
    if (state_q == ST_MUL) begin
      prod_q <= prod_d;
      step_q <= step_q + 4'd1;
      case (step_q)
        4'd1, 4'd2: acc_a_q <= acc_a_q + prod_q;
        4'd3: acc_b_q <= acc_b_q + prod_q;
        4'd4: acc_b_q <= acc_b_q - prod_q;
        4'd5, 4'd6: acc_c_q <= acc_c_q + prod_q;
        4'd7, 4'd8, 4'd9: ss_q <= ss_q + prod_q;
        4'd10, 4'd11, 4'd12: dot_q <= dot_q + prod_q;
        default: ;
      endcase
      if (step_q == 4'd12 && zero_q) align_q <= align_zero;
    end
    if (state_q == ST_ROOT && sd_done) align_q <= align_div;
    if (load_out) begin
      res_mon_q <= slot_q;
      in_view_q <= visible;
      res_align_q <= align_q[15:0];
      act_q <= act_d;
      left_cnt_q <= new_cnt;
    end
  end

  assign out_valid_o = out_valid_q;
  assign result_monitor_o = res_mon_q;
  assign in_view_o = in_view_q;
  assign alignment_o = res_align_q;
  assign action_o = act_q;
  assign hold_left_o = left_cnt_q;

endmodule

/* src/vcc_checker.sv */
// ----------------------------------------------------------------------------
// View cone cull checker
// Port-level assertions on results and busy behavior of the block.
// ----------------------------------------------------------------------------
module vcc_checker #(
  parameter int unsigned MONITOR_SLOTS = vcc_pkg::MONITOR_SLOTS_DEF
) (
  input logic                          clk_i,
  input logic                          rst_ni,
  input logic                          in_valid_i,
  input logic                          in_ready_o,
  input logic [1:0]                    kind_i,
  input logic [3:0]                    monitor_index_i,
  input logic                          decoder_present_i,
  input logic                          out_valid_o,
  input logic                          out_ready_i,
  input logic                          in_view_o,
  input logic signed [15:0]            alignment_o,
  input logic [1:0]                    action_o,
  input logic [7:0]                    hold_left_o
);
  import vcc_pkg::*;

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(alignment_o))
    else $error("Result changed before its transaction completed.");

  a_resume_in_view: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && action_o == ACT_RESUME |-> in_view_o)
    else $error("Resume given for a monitor out of view.");

  a_pause_expired: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && action_o == ACT_PAUSE |-> !in_view_o && hold_left_o == 8'd0)
    else $error("Pause given before the hold countdown expired.");

  a_align_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> alignment_o <= UNIT_ONE && alignment_o >= -UNIT_ONE)
    else $error("Alignment outside the unit range.");

  a_test_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o && kind_i == KIND_TEST && decoder_present_i &&
    32'(monitor_index_i) < MONITOR_SLOTS |=> !in_ready_o)
    else $error("Input ready while a monitor test is running.");

endmodule

bind view_cone_cull_with_hysteresis vcc_checker #(
  .MONITOR_SLOTS(MONITOR_SLOTS)
) u_vcc_checker (.*);
